[design/ffp_pkg.sv]
// ffp_pkg: shared types and constants for the first-fit lifetime placer.
// Used by ffp_ctrl, ffp_dpath and first_fit_lifetime_placer. No dependencies.
`timescale 1ns / 1ps

package ffp_pkg;

    // fixed field widths of the item and result transactions
    localparam int SIZE_W   = 32;
    localparam int ALIGN_W  = 5;
    localparam int LIFE_W   = 16;
    localparam int MASK_W   = 16;
    localparam int OFFS_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int PEAK_W   = 33;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_CAP   = 1'b1;

    // result status codes
    localparam logic STATUS_PLACED = 1'b0;
    localparam logic STATUS_FULL   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_BUMP,
        S_SAT,
        S_WRITE,
        S_REPORT
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic load;     // latch item, apply pool start, seed candidate
        logic cmp;      // one compare pass over all slots
        logic bump;     // raise candidate past the selected hit
        logic sat;      // saturate candidate, raise peak to floor
        logic write;    // record slot, update peak and count
        logic report;   // drive result registers
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic hit;        // last compare pass found a blocking slot
        logic last_pass;  // pass budget used up
    } t_stat;

endpackage

[design/ffp_ctrl.sv]
// ffp_ctrl: sequencer for the placer; issues one command per state.
// Depends on ffp_pkg (t_state, t_cmd, t_stat).
`timescale 1ns / 1ps

module ffp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ffp_pkg::t_stat i_stat,
    output ffp_pkg::t_cmd  o_cmd
);
    import ffp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_BUMP;
            end
            S_BUMP: begin
                if (i_stat.hit && !i_stat.last_pass) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                n_state = S_REPORT;
            end
            S_REPORT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_CMP:    o_cmd.cmp    = 1'b1;
            S_BUMP:   o_cmd.bump   = 1'b1;
            S_SAT:    o_cmd.sat    = 1'b1;
            S_WRITE:  o_cmd.write  = 1'b1;
            S_REPORT: o_cmd.report = 1'b1;
            default:  busy         = 1'b1;
        endcase
    end

    // an accepted transaction always starts with a compare pass
    a_start_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && start) |=> (r_state == S_CMP))
        else $error("accepted item did not enter compare pass");

    // every compare pass is followed by a bump decision
    a_cmp_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> (r_state == S_BUMP))
        else $error("compare pass not followed by bump");

endmodule

[design/ffp_dpath.sv]
// ffp_dpath: slot table, candidate search, peak tracking and result registers.
// Depends on ffp_pkg (field widths, codes, t_cmd, t_stat).
`timescale 1ns / 1ps

module ffp_dpath #(
    parameter int MAX_PLACED = 16,
    parameter int ADDR_BITS  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ffp_pkg::t_cmd                       i_cmd,
    output ffp_pkg::t_stat                      o_stat,
    input  logic                                i_cfg_we,
    input  logic [ffp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ffp_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_start_pool,
    input  logic [ffp_pkg::SIZE_W-1:0]          i_buf_size,
    input  logic [ffp_pkg::ALIGN_W-1:0]         i_align_log2,
    input  logic [ffp_pkg::LIFE_W-1:0]          i_life_start,
    input  logic [ffp_pkg::LIFE_W-1:0]          i_life_end,
    input  logic [ffp_pkg::MASK_W-1:0]          i_apart_mask,
    output logic [ffp_pkg::OFFS_W-1:0]          o_place_offset,
    output logic [ffp_pkg::SLOT_W-1:0]          o_slot_index,
    output logic [ffp_pkg::PEAK_W-1:0]          o_pool_peak,
    output logic                                o_cap_exceeded,
    output logic                                o_status,
    output logic                                o_done
);
    import ffp_pkg::*;

    localparam int OW  = ADDR_BITS;
    localparam int EW  = ADDR_BITS + 1;
    // wide enough for aligned candidates plus size without wrap
    localparam int CW  = ((EW > 32) ? EW : 32) + 2;
    localparam int NW  = $clog2(MAX_PLACED + 1);
    localparam int SW  = $clog2(MAX_PLACED);
    localparam int PW  = $clog2(MAX_PLACED + 2);
    localparam int MW  = (MAX_PLACED > MASK_W) ? MAX_PLACED : MASK_W;

    localparam logic [CW-1:0] OFF_MAX = CW'({OW{1'b1}});
    localparam logic [CW-1:0] END_MAX = CW'({EW{1'b1}});

    // configuration
    logic [CFG_W-1:0]   r_floor;
    logic [CFG_W-1:0]   r_cap;

    // latched item
    logic [SIZE_W-1:0]  r_size;
    logic [CW-1:0]      r_amask;
    logic [LIFE_W-1:0]  r_ls;
    logic [LIFE_W-1:0]  r_le;
    logic [MASK_W-1:0]  r_mask;

    // search state
    logic [OW-1:0]      r_fl;
    logic [CW-1:0]      r_cand;
    logic               r_hit;
    logic [EW-1:0]      r_sel;
    logic [PW-1:0]      r_pass;
    logic [OW-1:0]      r_off;

    // pool state
    logic [NW-1:0]      r_count;
    logic [EW-1:0]      r_peak;
    logic [OW-1:0]      r_slot_off [MAX_PLACED];
    logic [EW-1:0]      r_slot_end [MAX_PLACED];
    logic [LIFE_W-1:0]  r_slot_ls  [MAX_PLACED];
    logic [LIFE_W-1:0]  r_slot_le  [MAX_PLACED];

    // results
    logic [OFFS_W-1:0]  r_o_off;
    logic [SLOT_W-1:0]  r_o_slot;
    logic [EW-1:0]      r_o_peak;
    logic               r_o_status;
    logic               r_done;

    // ---------------- combinational ----------------
    logic [SIZE_W-1:0]  in_amask_n;
    logic [CW-1:0]      in_amask;
    logic [CW-1:0]      fl_wide;
    logic [OW-1:0]      fl_sat;
    logic [CW-1:0]      cand_seed;
    logic [CW-1:0]      cand_end;
    logic [MW-1:0]      mask_ext;
    logic [MAX_PLACED-1:0] hit_vec;
    logic [EW-1:0]      sel_end;
    logic [CW-1:0]      bumped;
    logic [CW-1:0]      end_sum;
    logic [EW-1:0]      end_sat;
    logic               full;
    logic [CW-1:0]      cnt_wide;

    // low-bit mask built at item width, then zero-extended
    assign in_amask_n = ~({SIZE_W{1'b1}} << i_align_log2);
    assign in_amask   = {{(CW-SIZE_W){1'b0}}, in_amask_n};
    assign fl_wide   = CW'(r_floor);
    assign fl_sat    = (|fl_wide[CW-1:OW]) ? {OW{1'b1}} : fl_wide[OW-1:0];
    assign cand_seed = (CW'(fl_sat) + in_amask) & ~in_amask;
    assign cand_end  = r_cand + CW'(r_size);
    assign mask_ext  = MW'(r_mask);

    always_comb begin
        for (int i = 0; i < MAX_PLACED; i++) begin
            hit_vec[i] = (NW'(i) < r_count)
                && ((r_ls < r_slot_le[i] && r_slot_ls[i] < r_le) || mask_ext[i])
                && (CW'(r_slot_off[i]) < cand_end)
                && (CW'(r_slot_end[i]) > r_cand);
        end
    end

    // lowest-index hit; any hit's end is a valid jump, no fit lies below it
    always_comb begin
        sel_end = '0;
        for (int i = MAX_PLACED - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                sel_end = r_slot_end[i];
            end
        end
    end

    assign bumped   = (CW'(r_sel) + r_amask) & ~r_amask;
    assign end_sum  = CW'(r_off) + CW'(r_size);
    assign end_sat  = (end_sum > END_MAX) ? {EW{1'b1}} : end_sum[EW-1:0];
    assign full     = (r_count == NW'(MAX_PLACED));
    assign cnt_wide  = CW'(r_count);

    assign o_stat.hit       = r_hit;
    assign o_stat.last_pass = (r_pass == (PW'(r_count) + PW'(1)));

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= '0;
            r_cap   <= '0;
            r_count <= '0;
            r_peak  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.report;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FLOOR_BASE: r_floor <= i_cfg_data;
                    CFG_POOL_CAP:   r_cap   <= i_cfg_data;
                    default:        r_cap   <= r_cap;
                endcase
            end
            if (i_cmd.load && i_start_pool) begin
                r_count <= '0;
                r_peak  <= '0;
            end
            if (i_cmd.sat && (EW'(r_fl) > r_peak)) begin
                r_peak <= EW'(r_fl);
            end
            if (i_cmd.write && !full) begin
                r_count <= r_count + NW'(1);
                if (end_sat > r_peak) begin
                    r_peak <= end_sat;
                end
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_size  <= i_buf_size;
            r_amask <= in_amask;
            r_ls    <= i_life_start;
            r_le    <= i_life_end;
            r_mask  <= i_apart_mask;
            r_fl    <= fl_sat;
            r_cand  <= cand_seed;
            r_pass  <= '0;
        end
        if (i_cmd.cmp) begin
            r_hit  <= |hit_vec;
            r_sel  <= sel_end;
            r_pass <= r_pass + PW'(1);
        end
        if (i_cmd.bump && r_hit) begin
            r_cand <= bumped;
        end
        if (i_cmd.sat) begin
            r_off <= (r_cand > OFF_MAX) ? {OW{1'b1}} : r_cand[OW-1:0];
        end
        if (i_cmd.write) begin
            r_o_off <= OFFS_W'(r_off);
            if (!full) begin
                r_slot_off[r_count[SW-1:0]] <= r_off;
                r_slot_end[r_count[SW-1:0]] <= end_sat;
                r_slot_ls[r_count[SW-1:0]]  <= r_ls;
                r_slot_le[r_count[SW-1:0]]  <= r_le;
                r_o_slot   <= cnt_wide[SLOT_W-1:0];
                r_o_status <= STATUS_PLACED;
            end else begin
                r_o_slot   <= '0;
                r_o_status <= STATUS_FULL;
            end
        end
        if (i_cmd.report) begin
            r_o_peak <= r_peak;
        end
    end

    logic [CW-1:0] o_peak_wide;
    assign o_peak_wide    = CW'(r_o_peak);
    assign o_place_offset = r_o_off;
    assign o_slot_index   = r_o_slot;
    assign o_pool_peak    = o_peak_wide[PEAK_W-1:0];
    assign o_cap_exceeded = (r_cap != '0) && (o_peak_wide > CW'(r_cap));
    assign o_status       = r_o_status;
    assign o_done         = r_done;

    // table never holds more entries than it has
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(MAX_PLACED))
        else $error("placed count beyond table depth");

    // a bump past a hit always raises the candidate
    a_bump_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.bump && r_hit) |=> (r_cand > $past(r_cand)))
        else $error("candidate did not rise on bump");

    // a clean pass leaves the candidate alone
    a_clean_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.bump && !r_hit) |=> $stable(r_cand))
        else $error("candidate moved after clean pass");

    // peak never falls below the saturated floor once raised for an item
    a_peak_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> (r_peak >= EW'(r_fl)))
        else $error("peak below floor at write");

endmodule

[design/first_fit_lifetime_placer.sv]
// first_fit_lifetime_placer: top level of the first-fit buffer placer.
// Instantiates ffp_ctrl and ffp_dpath; depends on ffp_pkg.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                       Payload
// item      in         start & !busy                   i_start_pool, i_buf_size,
//                                                      i_align_log2, i_life_start,
//                                                      i_life_end, i_apart_mask
// result    out        o_done, one cycle, no stall     o_place_offset, o_slot_index,
//                                                      o_pool_peak, o_cap_exceeded,
//                                                      o_status
// config    in         i_cfg_valid & o_cfg_ready       i_cfg_index, i_cfg_data
//
// Sequence: after accept, each compare/bump pass over the slot table either
//   bumps the candidate past a blocking slot or ends the loop; passes stop
//   when one is clean or when placed slots plus one have been made. Then
//   come saturate, record and report, and o_done is registered from report.
// The next item may be accepted in the cycle the strobe is shown.
// Reset: synchronous, active low; empties the table, zeroes peak and config.
// Stalls: the receiver cannot stall; results are shown for exactly one cycle.
// Config is always ready and must only be written while busy is low.

module first_fit_lifetime_placer #(
    parameter int MAX_PLACED = 16,
    parameter int ADDR_BITS  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item transaction
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_start_pool,
    input  logic [ffp_pkg::SIZE_W-1:0]          i_buf_size,
    input  logic [ffp_pkg::ALIGN_W-1:0]         i_align_log2,
    input  logic [ffp_pkg::LIFE_W-1:0]          i_life_start,
    input  logic [ffp_pkg::LIFE_W-1:0]          i_life_end,
    input  logic [ffp_pkg::MASK_W-1:0]          i_apart_mask,
    // result transaction
    output logic                                o_done,
    output logic [ffp_pkg::OFFS_W-1:0]          o_place_offset,
    output logic [ffp_pkg::SLOT_W-1:0]          o_slot_index,
    output logic [ffp_pkg::PEAK_W-1:0]          o_pool_peak,
    output logic                                o_cap_exceeded,
    output logic                                o_status,
    // configuration transaction
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ffp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ffp_pkg::CFG_W-1:0]           i_cfg_data
);
    import ffp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // registers are plain flops, so a write is always accepted
    assign o_cfg_ready = 1'b1;

    // sequencer: load, then compare/bump passes until clean or the pass
    // budget is used up, then saturate, record and report
    ffp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // slot table, candidate search and pool bookkeeping
    ffp_dpath #(
        .MAX_PLACED (MAX_PLACED),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_start_pool   (i_start_pool),
        .i_buf_size     (i_buf_size),
        .i_align_log2   (i_align_log2),
        .i_life_start   (i_life_start),
        .i_life_end     (i_life_end),
        .i_apart_mask   (i_apart_mask),
        .o_place_offset (o_place_offset),
        .o_slot_index   (o_slot_index),
        .o_pool_peak    (o_pool_peak),
        .o_cap_exceeded (o_cap_exceeded),
        .o_status       (o_status),
        .o_done         (o_done)
    );

endmodule

[sim/tb_top.sv]
// tb_top: self-checking testbench for first_fit_lifetime_placer.
// Uses the ffp_pkg types and the design sources under design/; needs nothing else.
`timescale 1ns / 1ps

module tb_top;
    import ffp_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = 32;
    localparam logic [63:0] OFFSET_LIMIT = (64'd1 << ADDR_W) - 1;
    localparam logic [63:0] END_LIMIT    = (64'd1 << (ADDR_W + 1)) - 1;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int RANDOM_PHASES   = 6;
    localparam int DRAIN_CYCLES    = 2 * TABLE_DEPTH + 6;

    // one buffer to place
    typedef struct {
        bit                start_pool;
        bit [SIZE_W-1:0]   buf_size;
        bit [ALIGN_W-1:0]  align_log2;
        bit [LIFE_W-1:0]   life_start;
        bit [LIFE_W-1:0]   life_end;
        bit [MASK_W-1:0]   apart_mask;
    } buf_request_t;

    // one placement result; logic so that X or Z on a port shows as a mismatch
    typedef struct {
        logic [OFFS_W-1:0] place_offset;
        logic [SLOT_W-1:0] slot_index;
        logic [PEAK_W-1:0] pool_peak;
        logic              cap_exceeded;
        logic              status;
    } placement_t;

    // Keeps a private copy of the slot table, the peak and the two registers,
    // predicts each placement as the request is accepted, and matches the
    // strobed results against those predictions in order.
    class placement_scoreboard;
        bit [CFG_W-1:0]  floor_reg;
        bit [CFG_W-1:0]  cap_reg;
        bit [OFFS_W-1:0] tbl_offset [TABLE_DEPTH];
        bit [PEAK_W-1:0] tbl_end [TABLE_DEPTH];
        bit [LIFE_W-1:0] tbl_life_start [TABLE_DEPTH];
        bit [LIFE_W-1:0] tbl_life_end [TABLE_DEPTH];
        int unsigned     used_slots;
        bit [PEAK_W-1:0] peak_reg;
        placement_t      pending_placements[$];
        int unsigned     errors;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] value);
            if (idx == CFG_FLOOR_BASE)
                floor_reg = value;
            else if (idx == CFG_POOL_CAP)
                cap_reg = value;
        endfunction

        // first-fit search: every pass tests all recorded slots and bumps the
        // candidate past the highest blocking end, until nothing blocks
        function void note_request(buf_request_t rq);
            placement_t  p;
            bit [63:0]   amask;
            bit [63:0]   cand;
            bit [63:0]   best;
            bit [63:0]   offs;
            bit [63:0]   fin;
            bit [63:0]   pk;
            bit          hit;
            bit          life_overlap;
            bit          kept_apart;
            int unsigned pass;
            int unsigned i;
            amask = (64'd1 << rq.align_log2) - 64'd1;
            if (rq.start_pool) begin
                used_slots = 0;
                peak_reg   = '0;
            end
            cand = ({32'd0, floor_reg} + amask) & ~amask;
            for (pass = 0; pass <= used_slots; pass++) begin
                hit  = 1'b0;
                best = '0;
                for (i = 0; i < used_slots; i++) begin
                    // lifetimes overlap when each starts before the other ends
                    life_overlap = (rq.life_start < tbl_life_end[i]) &&
                                   (tbl_life_start[i] < rq.life_end);
                    kept_apart   = (i < MASK_W) && rq.apart_mask[i];
                    if ((life_overlap || kept_apart) &&
                        (64'(tbl_offset[i]) < cand + 64'(rq.buf_size)) &&
                        (64'(tbl_end[i]) > cand)) begin
                        hit = 1'b1;
                        if (64'(tbl_end[i]) > best)
                            best = 64'(tbl_end[i]);
                    end
                end
                if (!hit)
                    break;
                cand = (best + amask) & ~amask;
            end
            offs = (cand > OFFSET_LIMIT) ? OFFSET_LIMIT : cand;
            fin  = offs + 64'(rq.buf_size);
            if (fin > END_LIMIT)
                fin = END_LIMIT;
            pk = 64'(peak_reg);
            if (64'(floor_reg) > pk)
                pk = 64'(floor_reg);
            p.slot_index = '0;
            if (used_slots < TABLE_DEPTH) begin
                p.slot_index               = SLOT_W'(used_slots);
                tbl_offset[used_slots]     = offs[OFFS_W-1:0];
                tbl_end[used_slots]        = fin[PEAK_W-1:0];
                tbl_life_start[used_slots] = rq.life_start;
                tbl_life_end[used_slots]   = rq.life_end;
                used_slots++;
                if (fin > pk)
                    pk = fin;
                p.status = STATUS_PLACED;
            end else begin
                // table full: offset still reported, nothing recorded
                p.status = STATUS_FULL;
            end
            peak_reg       = pk[PEAK_W-1:0];
            p.place_offset = offs[OFFS_W-1:0];
            p.pool_peak    = peak_reg;
            p.cap_exceeded = (cap_reg != 0) && (64'(peak_reg) > 64'(cap_reg));
            pending_placements.insert(pending_placements.size(), p);
        endfunction

        function void check_result(placement_t got);
            placement_t exp_p;
            if (pending_placements.size() == 0) begin
                $error("result with no request outstanding: offset %0h slot %0d",
                       got.place_offset, got.slot_index);
                errors++;
                return;
            end
            exp_p = pending_placements.pop_front();
            if (got.place_offset !== exp_p.place_offset) begin
                $error("place_offset: expected %0h, actual %0h",
                       exp_p.place_offset, got.place_offset);
                errors++;
            end
            if (got.slot_index !== exp_p.slot_index) begin
                $error("slot_index: expected %0d, actual %0d",
                       exp_p.slot_index, got.slot_index);
                errors++;
            end
            if (got.pool_peak !== exp_p.pool_peak) begin
                $error("pool_peak: expected %0h, actual %0h",
                       exp_p.pool_peak, got.pool_peak);
                errors++;
            end
            if (got.cap_exceeded !== exp_p.cap_exceeded) begin
                $error("cap_exceeded: expected %0b, actual %0b",
                       exp_p.cap_exceeded, got.cap_exceeded);
                errors++;
            end
            if (got.status !== exp_p.status) begin
                $error("status: expected %0b, actual %0b",
                       exp_p.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_start_pool = 1'b0;
    logic [SIZE_W-1:0]    i_buf_size = '0;
    logic [ALIGN_W-1:0]   i_align_log2 = '0;
    logic [LIFE_W-1:0]    i_life_start = '0;
    logic [LIFE_W-1:0]    i_life_end = '0;
    logic [MASK_W-1:0]    i_apart_mask = '0;
    logic                 o_done;
    logic [OFFS_W-1:0]    o_place_offset;
    logic [SLOT_W-1:0]    o_slot_index;
    logic [PEAK_W-1:0]    o_pool_peak;
    logic                 o_cap_exceeded;
    logic                 o_status;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    placement_scoreboard sb = new();
    bit no_gaps = 1'b0;     // set during the stretch with back-to-back requests

    first_fit_lifetime_placer #(
        .MAX_PLACED(TABLE_DEPTH),
        .ADDR_BITS (ADDR_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_start_pool  (i_start_pool),
        .i_buf_size    (i_buf_size),
        .i_align_log2  (i_align_log2),
        .i_life_start  (i_life_start),
        .i_life_end    (i_life_end),
        .i_apart_mask  (i_apart_mask),
        .o_done        (o_done),
        .o_place_offset(o_place_offset),
        .o_slot_index  (o_slot_index),
        .o_pool_peak   (o_pool_peak),
        .o_cap_exceeded(o_cap_exceeded),
        .o_status      (o_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // results are strobed for a single cycle; sample the pre-edge values
    always @(posedge i_clk) begin
        placement_t got;
        if (i_rst_n && o_done) begin
            got.place_offset = o_place_offset;
            got.slot_index   = o_slot_index;
            got.pool_peak    = o_pool_peak;
            got.cap_exceeded = o_cap_exceeded;
            got.status       = o_status;
            sb.check_result(got);
        end
    end

    function automatic buf_request_t mk_request(bit sp, bit [SIZE_W-1:0] size,
                                               bit [ALIGN_W-1:0] al, bit [LIFE_W-1:0] ls,
                                               bit [LIFE_W-1:0] le, bit [MASK_W-1:0] mask);
        buf_request_t rq;
        rq.start_pool = sp;
        rq.buf_size   = size;
        rq.align_log2 = al;
        rq.life_start = ls;
        rq.life_end   = le;
        rq.apart_mask = mask;
        return rq;
    endfunction

    // Typical pool member: small sizes and short lifetimes so that buffers
    // collide often; now and then a huge size, a big alignment or an empty life.
    function automatic buf_request_t pool_request(bit first);
        buf_request_t rq;
        int unsigned  pick;
        rq.start_pool = first;
        pick = $urandom_range(99);
        if (pick < 5)
            rq.buf_size = '0;
        else if (pick < 15)
            rq.buf_size = $urandom();
        else
            rq.buf_size = $urandom_range(1, 96);
        rq.align_log2 = ($urandom_range(9) < 8) ? ALIGN_W'($urandom_range(0, 5))
                                                : ALIGN_W'($urandom_range(0, 31));
        rq.life_start = LIFE_W'($urandom_range(0, 40));
        if ($urandom_range(9) == 0)
            rq.life_end = LIFE_W'($urandom_range(0, rq.life_start));
        else
            rq.life_end = rq.life_start + LIFE_W'($urandom_range(1, 20));
        pick = $urandom_range(3);
        if (pick < 2)
            rq.apart_mask = '0;
        else if (pick == 2)
            rq.apart_mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
        else
            rq.apart_mask = MASK_W'($urandom());
        return rq;
    endfunction

    function automatic buf_request_t noise_request();
        return mk_request(1'($urandom_range(1)), $urandom(), ALIGN_W'($urandom()),
                          LIFE_W'($urandom()), LIFE_W'($urandom()), MASK_W'($urandom()));
    endfunction

    // Present one request and hold it until the edge that accepts it.
    // Called right after a rising edge; leaves start high on return.
    task automatic send_request(input buf_request_t rq);
        if (!no_gaps && $urandom_range(99) < 16) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_start_pool <= rq.start_pool;
        i_buf_size   <= rq.buf_size;
        i_align_log2 <= rq.align_log2;
        i_life_start <= rq.life_start;
        i_life_end   <= rq.life_end;
        i_apart_mask <= rq.apart_mask;
        do @(posedge i_clk); while (busy);
        sb.note_request(rq);
    endtask

    // drop start and wait until every placement has come back
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending_placements.size() != 0 || busy);
    endtask

    // both registers back to back, valid lowered only after the second
    task automatic set_pool_limits(input bit [CFG_W-1:0] floor_v, input bit [CFG_W-1:0] cap_v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_FLOOR_BASE;
        i_cfg_data  <= floor_v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(CFG_FLOOR_BASE, floor_v);
        i_cfg_index <= CFG_POOL_CAP;
        i_cfg_data  <= cap_v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(CFG_POOL_CAP, cap_v);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned ph;
        int unsigned n;
        int unsigned k;
        int unsigned run_len;
        int unsigned sent;
        sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: registers still at reset, no start flag on the first item.
        send_request(mk_request(1'b0, 16, 0, 0, 10, 16'h0000));
        // overlapping lifetime, bumped past slot 0 and aligned to 8
        send_request(mk_request(1'b0, 8, 3, 5, 15, 16'h0000));
        // disjoint lifetime, largest size
        send_request(mk_request(1'b0, 32'hFFFF_FFFF, 0, 20, 30, 16'h0000));
        // empty lifetime, only the apart bit on slot 0 blocks it
        send_request(mk_request(1'b0, 4, 0, 40, 40, 16'h0001));
        // zero size never collides, even with every mask bit set
        send_request(mk_request(1'b0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
        // largest alignment pushes the candidate past the address range
        send_request(mk_request(1'b0, 1, 31, 25, 26, 16'h0000));
        // fresh pool
        send_request(mk_request(1'b1, 100, 2, 0, 16'hFFFF, 16'hFFFF));
        drain();

        // Floor at the top of the range, tiny cap: saturation and over-cap.
        set_pool_limits(32'hFFFF_FFFF, 32'h1);
        send_request(mk_request(1'b1, 32'hFFFF_FFFF, 0, 0, 100, 16'h0000));
        send_request(mk_request(1'b0, 16, 5, 50, 60, 16'h0000));
        drain();

        // Fill all sixteen slots, then one more that finds the table full.
        set_pool_limits(32'h100, 32'h180);
        for (k = 0; k < TABLE_DEPTH; k++)
            send_request(mk_request(k == 0, 8 + k, ALIGN_W'(k % 4), 0, 16'hFFFF,
                                    (k % 2) ? 16'hFFFF : 16'h0000));
        send_request(mk_request(1'b0, 8, 0, 16'hFFFF, 16'hFFFF, 16'h0000));
        drain();

        // Random part: pools of random length under a new register setting
        // per phase; some pools overrun the table, a tenth of items are noise.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: set_pool_limits(32'h0, 32'h0);
                1: set_pool_limits($urandom_range(0, 64), $urandom_range(100, 300));
                2: set_pool_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: set_pool_limits($urandom(), 32'h1);
                4: set_pool_limits(32'h0, $urandom_range(1, 2000));
                default: set_pool_limits($urandom_range(0, 16'hFFFF), 32'h0);
            endcase
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                run_len = ($urandom_range(9) == 0) ? $urandom_range(17, 22)
                                                   : $urandom_range(1, 12);
                for (k = 0; k < run_len && n < ITEMS_PER_PHASE; k++) begin
                    no_gaps = (sent >= 180 && sent < 280);
                    if ($urandom_range(9) == 0)
                        send_request(noise_request());
                    else
                        send_request(pool_request(k == 0));
                    n++;
                    sent++;
                end
            end
            drain();
        end

        // quiet period: any late strobe shows up as an unexpected result
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
